@@ hdl/rfc_pkg.sv @@
// Shared types and constants of the radio receive frame checker.
`default_nettype none

package rfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned CORR_W   = 7;

    // Two footer bytes follow the payload.
    localparam logic [BYTE_W-1:0] FOOT_BYTES = 8'd2;
    localparam int unsigned CRC_OK_BIT = 7;
    localparam logic [BYTE_W-1:0] CORR_MASK = 8'h7f;

    localparam logic [LEN_W-1:0]  MAX_PAYLOAD_RST = 7'd125;
    localparam logic [BYTE_W-1:0] RSSI_BIAS_RST   = 8'hd3;

    // Configuration register indexes.
    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_RSSI_BIAS   = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA   = 3'd0,
        ST_OK     = 3'd1,
        ST_BADCRC = 3'd2,
        ST_SYNC   = 3'd3,
        ST_SHORT  = 3'd4,
        ST_LONG   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        PH_LEN = 4'b0001,
        PH_PAY = 4'b0010,
        PH_F0  = 4'b0100,
        PH_F1  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic              present;
        logic [BYTE_W-1:0] data_byte;
        status_t           status;
        logic [LEN_W-1:0]  payload_length;
        logic signed [BYTE_W-1:0] rssi_dbm;
        logic [CORR_W-1:0] correlation;
        logic              flush_request;
        logic              last;
    } result_t;

endpackage : rfc_pkg

`default_nettype wire

@@ hdl/rfc_parser.sv @@
// Frame parser: frame state, length checks and per-byte result decode.
`default_nettype none

module rfc_parser #(
    parameter int unsigned MAX_FRAME_LEN = 127
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      advance,
    input  wire logic [rfc_pkg::BYTE_W-1:0] rx_byte,
    input  wire logic [rfc_pkg::LEN_W-1:0]  max_payload,
    input  wire logic [rfc_pkg::BYTE_W-1:0] rssi_bias,
    output rfc_pkg::result_t                result
);
    import rfc_pkg::*;

    localparam logic [BYTE_W-1:0] MAX_LEN_B = BYTE_W'(MAX_FRAME_LEN);

    phase_t            phase_reg, phase_next;
    logic [LEN_W-1:0]  bytes_left_reg, bytes_left_next;
    logic [LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [BYTE_W-1:0] rssi_raw_reg, rssi_raw_next;

    logic [BYTE_W-1:0] plen_full;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  left_dec;

    assign plen_full = rx_byte - FOOT_BYTES;
    assign plen      = plen_full[LEN_W-1:0];
    assign left_dec  = bytes_left_reg - LEN_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        frame_len_next  = frame_len_reg;
        rssi_raw_next   = rssi_raw_reg;

        result                = '0;
        result.status         = ST_DATA;

        case (phase_reg)
            PH_LEN:
            begin
                if (rx_byte > MAX_LEN_B)
                begin
                    result.present       = 1'b1;
                    result.status        = ST_SYNC;
                    result.flush_request = 1'b1;
                    result.last          = 1'b1;
                end
                else if (rx_byte <= FOOT_BYTES)
                begin
                    result.present       = 1'b1;
                    result.status        = ST_SHORT;
                    result.flush_request = 1'b1;
                    result.last          = 1'b1;
                end
                else if (plen_full > {1'b0, max_payload})
                begin
                    result.present       = 1'b1;
                    result.status        = ST_LONG;
                    result.flush_request = 1'b1;
                    result.last          = 1'b1;
                end
                else
                begin
                    frame_len_next  = plen;
                    bytes_left_next = plen;
                    phase_next      = PH_PAY;
                end
            end
            PH_PAY:
            begin
                bytes_left_next  = left_dec;
                if (left_dec == '0)
                    phase_next = PH_F0;
                result.present   = 1'b1;
                result.data_byte = rx_byte;
            end
            PH_F0:
            begin
                rssi_raw_next = rx_byte;
                phase_next    = PH_F1;
            end
            PH_F1:
            begin
                phase_next     = PH_LEN;
                result.present = 1'b1;
                result.last    = 1'b1;
                if (rx_byte[CRC_OK_BIT])
                begin
                    result.status         = ST_OK;
                    result.payload_length = frame_len_reg;
                    result.rssi_dbm       = $signed(rssi_raw_reg + rssi_bias);
                    result.correlation    = CORR_W'(rx_byte & CORR_MASK);
                end
                else
                begin
                    result.status = ST_BADCRC;
                end
            end
            default:
            begin
                phase_next = PH_LEN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN;
            bytes_left_reg <= '0;
            frame_len_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            frame_len_reg  <= frame_len_next;
        end
    end

    // RSSI byte is always written in footer 0 before footer 1 reads it.
    always_ff @(posedge clk)
    begin
        if (advance)
            rssi_raw_reg <= rssi_raw_next;
    end

endmodule : rfc_parser

`default_nettype wire

@@ hdl/rfc_out_stage.sv @@
// Result register of the checker with its valid flag toward the master side.
`default_nettype none

module rfc_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire rfc_pkg::result_t result,
    input  wire logic             out_ready,
    output logic                  out_free,
    output logic                  out_valid,
    output rfc_pkg::result_t      out_result
);
    import rfc_pkg::*;

    logic    valid_reg, valid_next;
    result_t result_reg;
    logic    load;

    assign out_free = !valid_reg || out_ready;
    assign load     = advance && result.present;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule : rfc_out_stage

`default_nettype wire

@@ hdl/radio_rx_frame_checker_core.sv @@
// Top level of the radio receive frame checker: input register, config, parser, result register.
//
//   channel   direction  transaction content
//   s_axis    in         tdata: rx_byte
//   m_axis    out        tdata/tuser/tlast: one result per payload byte or frame end
//   cfg       in         cfg_addr 0 max_payload, 1 rssi_bias
//
// One byte per cycle sustained while m_axis_tready is high.
// The input register and the result register each hold one transaction; a byte
// moves on when the result register is empty or being drained in that cycle.
// Reset clears the frame phase, byte count and length; the next byte is taken as a length byte.
// A stall on m_axis backs up through the input register to s_axis_tready.
`default_nettype none

module radio_rx_frame_checker_core #(
    parameter int unsigned MAX_FRAME_LEN = 127
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] data_byte, [14:8] payload_length, [22:15] rssi_dbm,
    // [29:23] correlation, [30] flush_request, [31] zero
    output logic [31:0]      m_axis_tdata,
    output logic [2:0]       m_axis_tuser,   // [2:0] status
    output logic             m_axis_tlast,

    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);
    import rfc_pkg::*;

    logic [LEN_W-1:0]  max_payload_reg;
    logic [BYTE_W-1:0] rssi_bias_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic    advance;
    logic    out_free;
    result_t result;
    result_t out_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            rssi_bias_reg   <= RSSI_BIAS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MAX_PAYLOAD: max_payload_reg <= cfg_wdata[LEN_W-1:0];
                CFG_RSSI_BIAS:   rssi_bias_reg   <= cfg_wdata;
                default:         rssi_bias_reg   <= rssi_bias_reg;
            endcase
        end
    end

    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
    end

    rfc_parser #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .rx_byte     (in_byte_reg),
        .max_payload (max_payload_reg),
        .rssi_bias   (rssi_bias_reg),
        .result      (result)
    );

    rfc_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .result     (result),
        .out_ready  (m_axis_tready),
        .out_free   (out_free),
        .out_valid  (m_axis_tvalid),
        .out_result (out_result)
    );

    assign m_axis_tdata = {1'b0,
                           out_result.flush_request,
                           out_result.correlation,
                           out_result.rssi_dbm,
                           out_result.payload_length,
                           out_result.data_byte};
    assign m_axis_tuser = out_result.status;
    assign m_axis_tlast = out_result.last;

    // Payload bytes never end a frame or request a flush.
    a_data_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_DATA) |-> (!m_axis_tlast && !m_axis_tdata[30]))
        else $error("payload transaction marked last or flush");

    // Flush goes with the three length errors only.
    a_flush_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[30]) |->
            (m_axis_tuser == ST_SYNC || m_axis_tuser == ST_SHORT || m_axis_tuser == ST_LONG))
        else $error("flush on a non length error");

    // Payload length is reported on a good frame only.
    a_len_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[14:8] != 7'd0) |-> (m_axis_tuser == ST_OK))
        else $error("payload length on non ok result");

    // A held byte that cannot advance keeps the slave side stalled.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_free) |-> (!s_axis_tready ##1 in_valid_reg))
        else $error("input register dropped a transaction");

endmodule : radio_rx_frame_checker_core

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the radio receive frame checker core.
`timescale 1ns / 100ps

module tb_top;
    import rfc_pkg::*;

    localparam int unsigned MAX_FRAME_LEN = 127;
    localparam int unsigned DRAIN_CYCLES  = 6;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned N_PHASES      = 9;
    localparam int unsigned PHASE_ITEMS   = 147;
    localparam int unsigned CYCLE_LIMIT   = 300000;
    localparam int unsigned MAX_REPORTS   = 40;

    // One row of the directed stimulus: a register write or an rx byte,
    // optionally with its error result typed in.
    typedef struct packed {
        logic        is_cfg;
        logic        cfg_idx;
        logic [7:0]  val;
        logic        typed;
        status_t     st;
        logic        flush;
    } row_t;

    localparam int DIR_ROWS = 29;

    row_t dir_tab [DIR_ROWS] = '{
        '{1'b0, 1'b0, 8'hFF, 1'b1, ST_SYNC,   1'b1},
        '{1'b0, 1'b0, 8'h80, 1'b1, ST_SYNC,   1'b1},
        '{1'b0, 1'b0, 8'h00, 1'b1, ST_SHORT,  1'b1},
        '{1'b0, 1'b0, 8'h02, 1'b1, ST_SHORT,  1'b1},
        // shortest good frame, footer bytes at their top values
        '{1'b0, 1'b0, 8'h03, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'hFF, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'hFF, 1'b0, ST_DATA,   1'b0},
        // CRC bit clear
        '{1'b0, 1'b0, 8'h03, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'h11, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'h20, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'h7F, 1'b1, ST_BADCRC, 1'b0},
        '{1'b1, CFG_MAX_PAYLOAD, 8'd0, 1'b0, ST_DATA, 1'b0},
        '{1'b0, 1'b0, 8'h03, 1'b1, ST_LONG,   1'b1},
        '{1'b0, 1'b0, 8'h7F, 1'b1, ST_LONG,   1'b1},
        '{1'b1, CFG_RSSI_BIAS, 8'h7F, 1'b0, ST_DATA, 1'b0},
        '{1'b1, CFG_MAX_PAYLOAD, 8'd125, 1'b0, ST_DATA, 1'b0},
        // RSSI sum wraps to zero
        '{1'b0, 1'b0, 8'h03, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'h42, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'h81, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'h80, 1'b0, ST_DATA,   1'b0},
        '{1'b1, CFG_RSSI_BIAS, 8'h80, 1'b0, ST_DATA, 1'b0},
        '{1'b1, CFG_MAX_PAYLOAD, 8'd1, 1'b0, ST_DATA, 1'b0},
        '{1'b0, 1'b0, 8'h03, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'hA5, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'h00, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'hC5, 1'b0, ST_DATA,   1'b0},
        '{1'b0, 1'b0, 8'h04, 1'b1, ST_LONG,   1'b1},
        '{1'b0, 1'b0, 8'h80, 1'b1, ST_SYNC,   1'b1}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire logic   s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    wire logic   m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire logic [31:0] m_axis_tdata;
    wire logic [2:0]  m_axis_tuser;
    wire logic   m_axis_tlast;
    logic        cfg_we        = 1'b0;
    logic        cfg_addr      = 1'b0;
    logic [7:0]  cfg_wdata     = 8'd0;

    // predictor state and register shadows
    phase_t      rx_ph         = PH_LEN;
    logic [6:0]  bytes_left    = 7'd0;
    logic [6:0]  frame_len     = 7'd0;
    logic [7:0]  rssi_raw      = 8'd0;
    logic [6:0]  max_pl        = MAX_PAYLOAD_RST;
    logic [7:0]  rssi_off      = RSSI_BIAS_RST;

    result_t     frame_res_q [$];
    result_t     typed_res;
    result_t     want;
    bit          typed_next    = 1'b0;
    bit          idle_en       = 1'b1;
    int unsigned hold_reqs     = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned err_cnt       = 0;
    int unsigned rx_items      = 0;
    int unsigned n_writes      = 0;
    int unsigned n_pay         = 0;
    int unsigned n_ok          = 0;
    int unsigned n_badcrc      = 0;
    int unsigned n_lenerr      = 0;

    radio_rx_frame_checker_core #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Advances the frame parser by one byte; present marks a result.
    function automatic result_t parse_rx_byte(logic [7:0] b);
        result_t r;
        r = '0;
        r.status = ST_DATA;
        case (rx_ph)
            PH_LEN:
            begin
                if (b > MAX_FRAME_LEN)
                begin
                    r.present = 1'b1;
                    r.status = ST_SYNC;
                end
                else if (b <= FOOT_BYTES)
                begin
                    r.present = 1'b1;
                    r.status = ST_SHORT;
                end
                else if ((b - FOOT_BYTES) > max_pl)
                begin
                    r.present = 1'b1;
                    r.status = ST_LONG;
                end
                else
                begin
                    frame_len = 7'(b - FOOT_BYTES);
                    bytes_left = frame_len;
                    rx_ph = PH_PAY;
                end
                r.flush_request = r.present;
                r.last = r.present;
            end
            PH_PAY:
            begin
                bytes_left = bytes_left - 7'd1;
                if (bytes_left == 7'd0)
                    rx_ph = PH_F0;
                r.present = 1'b1;
                r.data_byte = b;
            end
            PH_F0:
            begin
                rssi_raw = b;
                rx_ph = PH_F1;
            end
            default:
            begin
                rx_ph = PH_LEN;
                r.present = 1'b1;
                r.last = 1'b1;
                if (b[CRC_OK_BIT])
                begin
                    r.status = ST_OK;
                    r.payload_length = frame_len;
                    r.rssi_dbm = rssi_raw + rssi_off;
                    r.correlation = 7'(b & CORR_MASK);
                end
                else
                    r.status = ST_BADCRC;
            end
        endcase
        return r;
    endfunction

    task automatic send_rx(input logic [7:0] b);
        result_t r;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = parse_rx_byte(b);
        if (typed_next)
        begin
            r = typed_res;
            typed_next = 1'b0;
        end
        if (r.present)
            frame_res_q.push_back(r);
        rx_items++;
    endtask

    // Stop offering, wait out every expected result and the bytes that give none.
    task automatic drain_frames();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (frame_res_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_MAX_PAYLOAD)
            max_pl = val[6:0];
        else
            rssi_off = val;
        n_writes++;
    endtask

    task automatic cmp_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
                $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, fname, exp_v, got_v);
        end
    endtask

    // Result side: random hold-off bursts plus the requested long hold.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_reqs != hold_served)
            begin
                hold_served++;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_res_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("%0t ns: unexpected result: expected none, %s 0x%0h tuser %0d",
                             $time, "actual tdata", m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = frame_res_q.pop_front();
                cmp_field("data_byte", want.data_byte, m_axis_tdata[7:0]);
                cmp_field("payload_length", want.payload_length, m_axis_tdata[14:8]);
                cmp_field("rssi_dbm", $unsigned(want.rssi_dbm), m_axis_tdata[22:15]);
                cmp_field("correlation", want.correlation, m_axis_tdata[29:23]);
                cmp_field("flush_request", want.flush_request, m_axis_tdata[30]);
                cmp_field("tdata[31]", 32'd0, m_axis_tdata[31]);
                cmp_field("status", want.status, m_axis_tuser);
                cmp_field("last", want.last, m_axis_tlast);
                case (want.status)
                    ST_DATA:   n_pay++;
                    ST_OK:     n_ok++;
                    ST_BADCRC: n_badcrc++;
                    default:   n_lenerr++;
                endcase
            end
        end
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned p;
        int unsigned start;
        int unsigned kind;
        int unsigned plen;
        int unsigned cap;
        logic [7:0]  mp;
        logic [7:0]  off;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
            begin
                drain_frames();
                write_reg(dir_tab[i].cfg_idx, dir_tab[i].val);
            end
            else
            begin
                if (dir_tab[i].typed)
                begin
                    typed_res = '0;
                    typed_res.present = 1'b1;
                    typed_res.status = dir_tab[i].st;
                    typed_res.flush_request = dir_tab[i].flush;
                    typed_res.last = 1'b1;
                    typed_next = 1'b1;
                end
                send_rx(dir_tab[i].val);
            end
        end

        for (p = 0; p < N_PHASES; p++)
        begin
            drain_frames();
            case (p)
                0:
                begin
                    mp = 8'd125;
                    off = 8'h7F;
                end
                1:
                begin
                    mp = 8'd0;
                    off = 8'h80;
                end
                2:
                begin
                    mp = 8'd1;
                    off = 8'h00;
                end
                default:
                begin
                    mp = 8'($urandom_range(0, 125));
                    off = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_MAX_PAYLOAD, mp);
            write_reg(CFG_RSSI_BIAS, off);
            idle_en = (p != N_PHASES - 1);
            if (p == 2 || p == 5)
                hold_reqs++;
            start = rx_items;
            while (rx_items - start < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 75)
                begin
                    if (max_pl == 7'd0)
                        send_rx(8'($urandom_range(3, 127)));
                    else
                    begin
                        cap = (max_pl < 7'd8) ? int'(max_pl) : 8;
                        if ($urandom_range(0, 24) == 0)
                            plen = max_pl;
                        else
                            plen = $urandom_range(1, cap);
                        send_rx(8'(plen + 2));
                        repeat (plen) send_rx(8'($urandom_range(0, 255)));
                        send_rx(8'($urandom_range(0, 255)));
                        send_rx(8'($urandom_range(0, 255)));
                    end
                end
                else if (kind < 88)
                begin
                    case ($urandom_range(0, 2))
                        0:       send_rx(8'($urandom_range(128, 255)));
                        1:       send_rx(8'($urandom_range(0, 2)));
                        default:
                        begin
                            if (max_pl < 7'd125)
                                send_rx(8'($urandom_range(int'(max_pl) + 3, 127)));
                            else
                                send_rx(8'($urandom_range(128, 255)));
                        end
                    endcase
                end
                else
                    repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
            end
        end

        drain_frames();
        $display("Run covered %0d rx bytes, %0d register writes, %0d long output stalls",
                 rx_items, n_writes, hold_served);
        $display("Results: %0d payload bytes, %0d good frames, %0d bad-CRC, %0d length errors",
                 n_pay, n_ok, n_badcrc, n_lenerr);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rfc_pkg.sv
hdl/rfc_parser.sv
hdl/rfc_out_stage.sv
hdl/radio_rx_frame_checker_core.sv
tb/sv/tb_top.sv
